@@ design/ipif_pkg.sv @@
// Shared types, constants and helpers for the IPv4/ICMP ingress filter.
`default_nettype none

package ipif_pkg;

	// Result codes
	typedef enum logic [3:0] {
		VERDICT_ECHO      = 4'd0,
		VERDICT_FORWARD   = 4'd1,
		VERDICT_WRONG_MAC = 4'd2,
		VERDICT_NOT_IPV4  = 4'd3,
		VERDICT_BAD_LEN   = 4'd4,
		VERDICT_BAD_IPSUM = 4'd5,
		VERDICT_NOT_ICMP  = 4'd6,
		VERDICT_BAD_ICMP  = 4'd7,
		VERDICT_NOT_ECHO  = 4'd8,
		VERDICT_SHORT     = 4'd9
	} verdict_t;

	// Configuration register indexes: MACs first, then IPv4 addresses
	localparam logic [2:0] CFG_FIRST_IP = 3'd4;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  ICMP_ECHO      = 8'd8;
	localparam logic [15:0] MIN_IP_LEN     = 16'd20;
	localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

	// Byte offsets within the frame
	localparam logic [15:0] OFS_ETYPE_HI   = 16'd12;
	localparam logic [15:0] OFS_ETYPE_LO   = 16'd13;
	localparam logic [15:0] OFS_IP_HDR     = 16'd14;
	localparam logic [15:0] OFS_TLEN_HI    = 16'd16;
	localparam logic [15:0] OFS_TLEN_LO    = 16'd17;
	localparam logic [15:0] OFS_PROTO      = 16'd23;
	localparam logic [15:0] OFS_IPSUM_HI   = 16'd24;
	localparam logic [15:0] OFS_IPSUM_LO   = 16'd25;
	localparam logic [15:0] OFS_DIP_FIRST  = 16'd30;
	localparam logic [15:0] OFS_IP_LAST    = 16'd33;
	localparam logic [15:0] OFS_ICMP       = 16'd34;
	localparam logic [15:0] OFS_ICMPSUM_HI = 16'd36;
	localparam logic [15:0] OFS_ICMPSUM_LO = 16'd37;
	localparam logic [15:0] OFS_SHORT_LAST = 16'd41;
	localparam logic [15:0] OFS_MAC_END    = 16'd6;
	localparam logic [15:0] OFS_SATURATED  = 16'hFFFF;

	// Captured header fields and finished sums, handed to the decision logic
	typedef struct packed {
		logic        short_frame;
		logic [47:0] dest_mac;
		logic [15:0] ether_kind;
		logic [15:0] total_length;
		logic [15:0] ip_sum;
		logic [15:0] ip_sum_stored;
		logic [31:0] dest_ip;
		logic [7:0]  proto;
		logic [7:0]  icmp_kind;
		logic [15:0] icmp_csum;
		logic [15:0] icmp_csum_rx;
	} hdr_t;

	// Ones'-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
		logic [16:0] sum;
		sum = {1'b0, acc} + {1'b0, word};
		return sum[16] ? (sum[15:0] + 16'd1) : sum[15:0];
	endfunction

endpackage

`default_nettype wire

@@ design/ipv4_icmp_ingress_filter.sv @@
// Top level of the IPv4/ICMP-echo ingress filter.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -------------------------------
//  in        sink       in_valid / in_stall       in_port, data_byte, frame_end
//  out       source     out_valid / out_stall     verdict, local_iface
//  cfg       sink       cfg_wr_en (no wait)       cfg_index, cfg_data
//
// One frame byte per cycle while in_stall is low: a byte moves from the input
// register into the parser; a final byte's verdict passes through the decision
// logic into the result register at the edge at which that byte leaves the input
// register, and out_valid rises with it.
// Reset clears the frame state, the interface addresses and both valid flags.
// Out stall holds only a final byte whose result slot is occupied; other
// bytes keep flowing while a verdict waits to be taken.
`default_nettype none

module ipv4_icmp_ingress_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	// byte stream
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  in_port,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	// verdicts
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       verdict,
	output logic [1:0]       local_iface
);
	import ipif_pkg::*;

	// interface addresses
	logic [3:0][47:0] mac_q;
	logic [3:0][31:0] ip_q;

	// input register
	logic       valid_s1;
	logic [1:0] port_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// result register
	logic       valid_s2;
	verdict_t   verdict_s2;
	logic [1:0] local_s2;

	logic       slot_free;
	logic       retire;
	logic       take;
	hdr_t       hdr;
	verdict_t   verdict_c;
	logic [1:0] local_c;

	// write configuration; only legal while the block is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q <= '0;
			ip_q  <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index < CFG_FIRST_IP)
				mac_q[cfg_index[1:0]] <= cfg_data;
			else
				ip_q[cfg_index[1:0]] <= cfg_data[31:0];
		end
	end

	// a final byte retires only into a free result slot; others always advance
	assign slot_free = !valid_s2 || !out_stall;
	assign retire    = valid_s1 && (!end_s1 || slot_free);
	assign in_stall  = valid_s1 && !retire;
	assign take      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			port_s1 <= in_port;
			byte_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

	ipif_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (retire),
		.data      (byte_s1),
		.last_byte (end_s1),
		.hdr       (hdr)
	);

	ipif_decide u_decide (
		.hdr         (hdr),
		.port        (port_s1),
		.mac_tab     (mac_q),
		.ip_tab      (ip_q),
		.verdict     (verdict_c),
		.local_iface (local_c)
	);

	// load a verdict on the final byte, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (retire && end_s1) begin
			valid_s2 <= 1'b1;
		end else if (valid_s2 && !out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && end_s1) begin
			verdict_s2 <= verdict_c;
			local_s2   <= local_c;
		end
	end

	assign out_valid   = valid_s2;
	assign verdict     = verdict_s2;
	assign local_iface = local_s2;

endmodule

`default_nettype wire

@@ design/ipif_parse.sv @@
// Frame state: byte counter, header capture and running checksums.
`default_nettype none

module ipif_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    data,
	input  wire logic          last_byte,
	output ipif_pkg::hdr_t     hdr
);
	import ipif_pkg::*;

	logic [15:0] offset_q, offset_d;
	logic [47:0] dmac_q, dmac_d;
	logic [15:0] etype_q, etype_d;
	logic [15:0] tlen_q, tlen_d;
	logic [15:0] ipsum_q, ipsum_d;
	logic [15:0] ipstored_q, ipstored_d;
	logic [31:0] dip_q, dip_d;
	logic [7:0]  proto_q, proto_d;
	logic [7:0]  ikind_q, ikind_d;
	logic [15:0] icsum_q, icsum_d;
	logic [15:0] icstored_q, icstored_d;
	logic [7:0]  hold_q, hold_d;

	logic        live;
	logic        is_sum;
	logic [7:0]  v;
	logic        pad;

	assign live = (offset_q != OFS_SATURATED);

	always_comb begin
		offset_d   = offset_q;
		dmac_d     = dmac_q;
		etype_d    = etype_q;
		tlen_d     = tlen_q;
		ipsum_d    = ipsum_q;
		ipstored_d = ipstored_q;
		dip_d      = dip_q;
		proto_d    = proto_q;
		ikind_d    = ikind_q;
		icsum_d    = icsum_q;
		icstored_d = icstored_q;
		hold_d     = hold_q;
		is_sum     = 1'b0;
		v          = data;
		if (live) begin
			offset_d = offset_q + 16'd1;
			if (offset_q < OFS_MAC_END)
				dmac_d = {dmac_q[39:0], data};
			if (offset_q == OFS_ETYPE_HI || offset_q == OFS_ETYPE_LO)
				etype_d = {etype_q[7:0], data};
			if (offset_q == OFS_TLEN_HI || offset_q == OFS_TLEN_LO)
				tlen_d = {tlen_q[7:0], data};
			if (offset_q == OFS_PROTO)
				proto_d = data;
			if (offset_q >= OFS_DIP_FIRST && offset_q <= OFS_IP_LAST)
				dip_d = {dip_q[23:0], data};
			if (offset_q == OFS_ICMP)
				ikind_d = data;
			if (offset_q == OFS_IPSUM_HI || offset_q == OFS_IPSUM_LO) begin
				ipstored_d = {ipstored_q[7:0], data};
				is_sum     = 1'b1;
			end
			if (offset_q == OFS_ICMPSUM_HI || offset_q == OFS_ICMPSUM_LO) begin
				icstored_d = {icstored_q[7:0], data};
				is_sum     = 1'b1;
			end
			// checksum fields count as zero in their own sums
			v = is_sum ? 8'd0 : data;
			if (offset_q >= OFS_IP_HDR) begin
				if (!offset_q[0])
					hold_d = v;
				else if (offset_q <= OFS_IP_LAST)
					ipsum_d = oc_add(ipsum_q, {hold_q, v});
				else
					icsum_d = oc_add(icsum_q, {hold_q, v});
			end
		end
	end

	// odd ICMP length: pad the final byte with a zero low byte
	assign pad = live ? (!offset_q[0] && offset_q >= OFS_ICMP) : 1'b1;

	always_comb begin
		hdr.short_frame     = live && (offset_q < OFS_SHORT_LAST);
		hdr.dest_mac        = dmac_q;
		hdr.ether_kind      = etype_q;
		hdr.total_length    = tlen_q;
		hdr.ip_sum          = ipsum_q;
		hdr.ip_sum_stored   = ipstored_q;
		hdr.dest_ip         = dip_q;
		hdr.proto           = proto_q;
		hdr.icmp_kind       = ikind_q;
		hdr.icmp_csum       = pad ? oc_add(icsum_d, {hold_d, 8'd0}) : icsum_d;
		hdr.icmp_csum_rx    = icstored_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			dmac_q     <= '0;
			etype_q    <= '0;
			tlen_q     <= '0;
			ipsum_q    <= '0;
			ipstored_q <= '0;
			dip_q      <= '0;
			proto_q    <= '0;
			ikind_q    <= '0;
			icsum_q    <= '0;
			icstored_q <= '0;
			hold_q     <= '0;
		end else if (step) begin
			if (last_byte) begin
				offset_q   <= '0;
				dmac_q     <= '0;
				etype_q    <= '0;
				tlen_q     <= '0;
				ipsum_q    <= '0;
				ipstored_q <= '0;
				dip_q      <= '0;
				proto_q    <= '0;
				ikind_q    <= '0;
				icsum_q    <= '0;
				icstored_q <= '0;
				hold_q     <= '0;
			end else begin
				offset_q   <= offset_d;
				dmac_q     <= dmac_d;
				etype_q    <= etype_d;
				tlen_q     <= tlen_d;
				ipsum_q    <= ipsum_d;
				ipstored_q <= ipstored_d;
				dip_q      <= dip_d;
				proto_q    <= proto_d;
				ikind_q    <= ikind_d;
				icsum_q    <= icsum_d;
				icstored_q <= icstored_d;
				hold_q     <= hold_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/ipif_decide.sv @@
// Verdict decision from captured header fields and interface addresses.
`default_nettype none

module ipif_decide (
	input  wire ipif_pkg::hdr_t     hdr,
	input  wire logic [1:0]         port,
	input  wire logic [3:0][47:0]   mac_tab,
	input  wire logic [3:0][31:0]   ip_tab,
	output ipif_pkg::verdict_t      verdict,
	output logic [1:0]              local_iface
);
	import ipif_pkg::*;

	logic       match;
	logic [1:0] match_idx;

	// lowest matching interface wins
	always_comb begin
		match     = 1'b0;
		match_idx = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (ip_tab[i] == hdr.dest_ip) begin
				match     = 1'b1;
				match_idx = 2'(i);
			end
		end
	end

	always_comb begin
		local_iface = 2'd0;
		if (hdr.short_frame)
			verdict = VERDICT_SHORT;
		else if (hdr.dest_mac != MAC_BROADCAST && hdr.dest_mac != mac_tab[port])
			verdict = VERDICT_WRONG_MAC;
		else if (hdr.ether_kind != ETHERTYPE_IPV4)
			verdict = VERDICT_NOT_IPV4;
		else if (hdr.total_length < MIN_IP_LEN)
			verdict = VERDICT_BAD_LEN;
		else if (hdr.ip_sum_stored != ~hdr.ip_sum)
			verdict = VERDICT_BAD_IPSUM;
		else if (!match)
			verdict = VERDICT_FORWARD;
		else begin
			local_iface = match_idx;
			if (hdr.proto != PROTO_ICMP)
				verdict = VERDICT_NOT_ICMP;
			else if (hdr.icmp_csum_rx != ~hdr.icmp_csum)
				verdict = VERDICT_BAD_ICMP;
			else if (hdr.icmp_kind != ICMP_ECHO)
				verdict = VERDICT_NOT_ECHO;
			else
				verdict = VERDICT_ECHO;
		end
	end

endmodule

`default_nettype wire
